/* rtl/core/lkv_pkg.sv */
// Package: shared constants, types and command/status structs of the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load;    // capture the accepted input item
        logic match;   // capture the lookup results
        logic update;  // apply the store and recency update
    } t_cmd;

    typedef struct packed {
        logic func_get;   // item in flight is a get
        logic out_valid;  // output register holds a result
    } t_status;

endpackage

/* rtl/core/lkv_if.sv */
// Interfaces: input, output and configuration channels of the LRU key-value cache.
interface lkv_in_if import lkv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkv_out_if import lkv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [VAL_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/lru_key_value_cache_core.sv */
// Top level: LRU key-value cache core, controller plus datapath.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------
//  i_in     | in  | valid / ready  | func, key[31:0], value[31:0]
//  o_out    | out | valid / ready  | found, read_value[31:0]
//  i_cfg    | in  | valid / ready  | data[4:0] (capacity)
//
// Each transaction is captured, then matched in parallel against all
// entries; the store and rank update then overlaps the capture of the
// next item, so a new item is taken while the last one finishes its update.
// Reset clears the valid bits and fill count at once; no clearing pass.
// A get result goes to an output register. A second get stalls in its update
// cycle while that register still holds an untaken result; sets never stall.
// The configuration port is always ready.
module lru_key_value_cache_core
    import lkv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkv_in_if.sink    i_in,
    lkv_out_if.source o_out,
    lkv_cfg_if.sink   i_cfg
);

    t_cmd    cmd;
    t_status status;

    // Capacity writes land at once; the user must issue them only while idle, the core does not enforce it.
    assign i_cfg.ready = 1'b1;

    // Sequence each transaction: accept, match, update.
    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    // Hold the entries, run the match and drive the result register.
    lkv_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_func     (i_in.func),
        .i_key      (i_in.key),
        .i_value    (i_in.value),
        .i_cfg_we   (i_cfg.valid && i_cfg.ready),
        .i_cfg_data (i_cfg.data),
        .o_out      (o_out)
    );

`ifndef ASSERT_OFF
    // A captured item is always matched in the following cycle.
    a_load_then_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.match)
        else $error("captured item not matched next cycle");

    // Finishing a get always presents a result.
    a_get_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.update && status.func_get) |=> o_out.valid)
        else $error("get finished without a result");

    // A result appears only after a get has finished.
    a_result_from_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.update && status.func_get))
        else $error("result appeared without a get");
`endif

endmodule

/* rtl/core/lkv_ctrl.sv */
// Controller: sequences accept, match and update of each transaction.
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   update_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A get may only finish once the output register is free or its result is being taken.
    assign update_go = !i_status.func_get || !i_status.out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.match  = 1'b0;
        o_cmd.update = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MATCH;
                end
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (update_go) begin
                    o_cmd.update = 1'b1;
                    o_in_ready   = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_MATCH;
                    end else begin
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/lkv_datapath.sv */
// Datapath: entry store, parallel key match, rank update and output register.
module lkv_datapath
    import lkv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_func,
    input  logic [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    lkv_out_if.source        o_out
);

    // Item registers
    logic             r_func;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    // Entry store
    logic [KEY_W-1:0] r_keys   [ENTRIES];
    logic [VAL_W-1:0] r_values [ENTRIES];
    logic [IDX_W-1:0] r_ranks  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0] r_fill;
    logic [CAP_W-1:0] r_capacity;

    // Match results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_hit_rank;
    logic [VAL_W-1:0] r_rd_value;
    logic             r_evict;
    logic [IDX_W-1:0] r_slot;

    // Output register
    logic             r_out_valid;
    logic             r_found;
    logic [VAL_W-1:0] r_read_value;

    logic [ENTRIES-1:0] hit_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   lru_rank;
    logic [CMP_W-1:0]   eff_cap;
    logic               full;

    // Clamp the capacity into one .. ENTRIES.
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_capacity);
        end
    end

    assign full     = CMP_W'(r_fill) >= eff_cap;
    // Valid ranks run 0 .. fill-1, so the oldest entry holds fill-1.
    assign lru_rank = IDX_W'(r_fill - CNT_W'(1));

    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == r_key);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (r_valid[i] && (r_ranks[i] == lru_rank)) begin
                victim_idx = victim_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.match) begin
            r_hit      <= |hit_vec;
            r_hit_idx  <= hit_idx;
            r_hit_rank <= r_ranks[hit_idx];
            r_rd_value <= r_values[hit_idx];
            r_evict    <= full;
            r_slot     <= full ? victim_idx : free_idx;
        end
        if (i_cmd.update) begin
            if (r_hit) begin
                if (r_func == FUNC_SET) begin
                    r_values[r_hit_idx] <= r_value;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_hit_idx) begin
                        r_ranks[i] <= '0;
                    end else if (r_valid[i] && (r_ranks[i] < r_hit_rank)) begin
                        r_ranks[i] <= r_ranks[i] + IDX_W'(1);
                    end
                end
            end else if (r_func == FUNC_SET) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_slot) begin
                        r_ranks[i] <= '0;
                    end else if (r_valid[i]) begin
                        r_ranks[i] <= r_ranks[i] + IDX_W'(1);
                    end
                end
                r_keys[r_slot]   <= r_key;
                r_values[r_slot] <= r_value;
            end
        end
        if (i_cmd.update && (r_func == FUNC_GET)) begin
            r_found      <= r_hit;
            r_read_value <= r_hit ? r_rd_value : MISS_VALUE;
        end
    end

    // Control state: valid bits, fill count, capacity, output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fill      <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.update && !r_hit && (r_func == FUNC_SET)) begin
                r_valid[r_slot] <= 1'b1;
                if (!r_evict) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.update && (r_func == FUNC_GET)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.func_get  = (r_func == FUNC_GET);
    assign o_status.out_valid = r_out_valid;

    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_found;
    assign o_out.read_value = r_read_value;

endmodule

/* verif/lkv_cache_checker.sv */
// Checker: watches the cache channels, predicts every read result and compares it.
module lkv_cache_checker
    import lkv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lkv_in_if    i_in,
    lkv_out_if   i_out,
    lkv_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
    } t_read_result;

    logic [KEY_W-1:0] slot_key   [ENTRIES];
    logic [VAL_W-1:0] slot_val   [ENTRIES];
    logic             slot_live  [ENTRIES];
    logic [IDX_W-1:0] slot_age   [ENTRIES];
    logic [CNT_W-1:0] live_count;
    logic [CAP_W-1:0] cap_reg;
    t_read_result     reads_due [$];
    t_read_result     want;
    int               fails = 0;

    function automatic int match_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_key[i] == k) return i;
        end
        return -1;
    endfunction

    // Zero acts as one; anything above the table size saturates.
    function automatic int usable_entries();
        int c;
        c = int'(cap_reg);
        if (c == 0) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    task automatic bump_to_front(int s);
        logic [IDX_W-1:0] r;
        r = slot_age[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
        end
        slot_age[s] = '0;
    endtask

    task automatic store_new_pair(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        int               slot;
        logic [IDX_W-1:0] oldest;
        slot   = -1;
        oldest = '0;
        // Full: drop the oldest entry first.
        if (int'(live_count) >= usable_entries()) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_live[i] && (slot < 0 || slot_age[i] > oldest)) begin
                    slot   = i;
                    oldest = slot_age[i];
                end
            end
            if (slot >= 0) begin
                slot_live[slot] = 1'b0;
                live_count--;
            end
        end
        if (slot < 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!slot_live[i]) begin
                    slot = i;
                    break;
                end
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i]) slot_age[i]++;
        end
        slot_key[slot]  = k;
        slot_val[slot]  = v;
        slot_age[slot]  = '0;
        slot_live[slot] = 1'b1;
        live_count++;
    endtask

    task automatic predict_item(logic func, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        int hit;
        hit = match_key(k);
        if (func == FUNC_SET) begin
            if (hit >= 0) begin
                slot_val[hit] = v;
                bump_to_front(hit);
            end else begin
                store_new_pair(k, v);
            end
        end else if (hit >= 0) begin
            bump_to_front(hit);
            reads_due.push_back('{found: 1'b1, read_value: slot_val[hit]});
        end else begin
            reads_due.push_back('{found: 1'b0, read_value: MISS_VALUE});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_reg    = CAP_RESET;
            live_count = '0;
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            reads_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) cap_reg = i_cfg.data;
            if (i_in.valid && i_in.ready) predict_item(i_in.func, i_in.key, i_in.value);
            if (i_out.valid && i_out.ready) begin
                if (reads_due.size() == 0) begin
                    $display("%0t: unexpected result, found %0b read_value %h",
                             $time, i_out.found, i_out.read_value);
                    fails++;
                end else begin
                    want = reads_due.pop_front();
                    if (i_out.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, i_out.found);
                        fails++;
                    end
                    if (i_out.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, i_out.read_value);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= reads_due.size();
        o_fail_count <= fails;
    end

endmodule

/* verif/tb_lru_key_value_cache_core.sv */
// Testbench top: drives the LRU key-value cache core and gives the verdict.
module tb_lru_key_value_cache_core;
    import lkv_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 12;
    // Watchdog limit, set many times above the slowest correct run.
    localparam int CYCLE_LIMIT = 300000;
    localparam int POOL_SIZE = 24;
    localparam int PHASE_ITEMS = 90;
    // A set can still be in its update cycle once the last read result is out.
    localparam int SETTLE_CYCLES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lkv_in_if  in_ch ();
    lkv_out_if out_ch ();
    lkv_cfg_if cfg_ch ();

    int pending;
    int fail_count;
    int cycle_count = 0;
    int stall_cycle = 0;
    int stall_mode = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [CAP_W-1:0] cap_plan [10] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16,
                                        5'd3, 5'd2, 5'd8, 5'd5, 5'd16};

    lru_key_value_cache_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lkv_cache_checker u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog: end the run if it hangs or results never arrive.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: switch between stall patterns, from always ready through
    // coin-flip to long regular stalls, so that back-pressure lands on a get
    // while it waits in the update state of the core.
    always @(posedge i_clk) begin
        if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_ch.ready <= (stall_cycle % 4 == 3);
            end
            default: begin
                out_ch.ready <= (stall_cycle % 16 < 11);
            end
        endcase
        stall_cycle++;
    end

    // Present one transaction and hold it until the core takes it. Valid is
    // left high so that the next call can follow back to back.
    task automatic send_item(logic func, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        in_ch.valid <= 1'b1;
        in_ch.func  <= func;
        in_ch.key   <= key;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic hold_off(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding read result, then let a
    // trailing set finish its update.
    task automatic drain_reads();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Capacity only changes while the core is idle.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_reads();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random gets and sets in bursts. Keys come mostly from the first span
    // entries of the pool, so that hits, updates and evictions all occur;
    // now and then a fresh random key gives a near-certain miss.
    task automatic run_random(int count, int span);
        int               sent;
        int               burst;
        int               gap;
        logic [KEY_W-1:0] key;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int j = 0; j < burst && sent < count; j++) begin
                if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, span - 1)];
                else key = $urandom;
                send_item(1'($urandom_range(0, 1)), key, $urandom);
                sent++;
            end
            // Once in a while wait for every result before going on.
            if ($urandom_range(0, 39) == 0) begin
                drain_reads();
            end else begin
                gap = $urandom_range(0, 6);
                if (gap > 0) hold_off(gap);
            end
        end
    endtask

    initial begin
        int eff;
        int span;

        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_GET;
        in_ch.key    = '0;
        in_ch.value  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity: a lookup in the empty store,
        // the key and value extremes, a stored value of all ones read back
        // as a hit, a plain miss and an update of an existing key.
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(FUNC_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(FUNC_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
        send_item(FUNC_SET, 32'h8000_0000, 32'h1234_5678);
        send_item(FUNC_GET, 32'h8000_0000, 32'h0000_0000);

        // Capacity one with four entries already held: each insert evicts
        // the oldest, and the old contents go out in recency order.
        write_capacity(5'd1);
        send_item(FUNC_SET, 32'h0000_0005, 32'h0000_0055);
        send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(FUNC_SET, 32'h0000_0006, 32'h0000_0066);
        send_item(FUNC_GET, 32'h0000_0005, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0006, 32'h0000_0000);

        // Random phases over a range of capacities: one, zero, values above
        // the table size, full size, and a drop to three right after a full
        // phase, which leaves more entries held than the new capacity.
        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            eff  = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p]);
            span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
            run_random(PHASE_ITEMS, span);
        end
        write_capacity(CAP_W'($urandom_range(0, 31)));
        run_random(PHASE_ITEMS, POOL_SIZE);

        drain_reads();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* lru_key_value_cache_core.f */
rtl/core/lkv_pkg.sv
rtl/core/lkv_if.sv
rtl/core/lkv_ctrl.sv
rtl/core/lkv_datapath.sv
rtl/core/lru_key_value_cache_core.sv
verif/lkv_cache_checker.sv
verif/tb_lru_key_value_cache_core.sv
